[src/vfhs_pkg.sv]
// ----------------------------------------------------------------------------
// Frame history selector package
// Shared widths, defaults and record types for the frame history selector.
// ----------------------------------------------------------------------------
`default_nettype none

package vfhs_pkg;

   localparam int unsigned TIME_W            = 64;
   localparam int unsigned TICKS_W           = 32;
   localparam int unsigned KIND_W            = 2;
   localparam int unsigned SLOT_FIELD_W      = 6;
   localparam int unsigned HISTORY_DEPTH_DEF = 8;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 32'd166667;

   // Event kinds on the request channel.
   localparam logic [KIND_W-1:0] KIND_FRAME        = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POLL         = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRESENT_DONE = 2'd2;

   // Running search record passed from cell to cell during a poll.
   typedef struct packed {
      logic                    valid;
      logic                    have_before;
      logic [TIME_W-1:0]       best_before;
      logic [SLOT_FIELD_W-1:0] idx_before;
      logic                    have_after;
      logic [TIME_W-1:0]       best_after;
      logic [SLOT_FIELD_W-1:0] idx_after;
   } scan_carry_type;

   // One result beat.
   typedef struct packed {
      logic                    stored;
      logic [SLOT_FIELD_W-1:0] stored_slot;
      logic                    present_due;
      logic                    frame_found;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic                    from_future;
   } result_type;

endpackage

`default_nettype wire

[src/vfhs_if.sv]
// ----------------------------------------------------------------------------
// Frame history selector channel interfaces
// Valid/ready channels for events, results and the period register.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfhs_req_if;
   import vfhs_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TIME_W-1:0]   time_now;

   modport source (output valid, output kind, output time_now, input ready);
   modport sink   (input valid, input kind, input time_now, output ready);
endinterface

interface vfhs_rsp_if;
   import vfhs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    stored;
   logic [SLOT_FIELD_W-1:0] stored_slot;
   logic                    present_due;
   logic                    frame_found;
   logic [SLOT_FIELD_W-1:0] chosen_slot;
   logic                    from_future;

   modport source (output valid, output stored, output stored_slot, output present_due,
                   output frame_found, output chosen_slot, output from_future,
                   input ready);
   modport sink   (input valid, input stored, input stored_slot, input present_due,
                   input frame_found, input chosen_slot, input from_future,
                   output ready);
endinterface

interface vfhs_csr_if;
   import vfhs_pkg::*;
   logic               valid;
   logic               ready;
   logic [TICKS_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/vfhs_cell.sv]
// ----------------------------------------------------------------------------
// Frame history cell
// Holds one history slot and folds it into the search record passing by.
// ----------------------------------------------------------------------------
`default_nettype none

module vfhs_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [vfhs_pkg::TIME_W-1:0]       wr_time,
   input  wire logic [vfhs_pkg::TIME_W-1:0]       target,
   input  wire vfhs_pkg::scan_carry_type          carry_prev,
   output      vfhs_pkg::scan_carry_type          carry_next
);
   import vfhs_pkg::*;

   localparam logic [SLOT_FIELD_W-1:0] MY_IDX = SLOT_FIELD_W'(CELL_INDEX);

   logic [TIME_W-1:0] slot_time_ff;
   logic              slot_valid_ff;
   scan_carry_type    carry_ff, carry_in;
   logic [TIME_W-1:0] dist_past, dist_future;
   logic              take_before, take_after;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_time_ff <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (wr_en) begin
         slot_valid_ff <= 1'b1;
      end
   end

   // A clear top bit on the past distance means the slot is at or before target.
   assign dist_past   = target - slot_time_ff;
   assign dist_future = slot_time_ff - target;

   assign take_before = slot_valid_ff && !dist_past[TIME_W-1] &&
                        (!carry_prev.have_before || dist_past < carry_prev.best_before);
   assign take_after  = slot_valid_ff && dist_past[TIME_W-1] &&
                        (!carry_prev.have_after || dist_future < carry_prev.best_after);

   always_comb begin
      carry_in = carry_prev;
      if (take_before) begin
         carry_in.have_before = 1'b1;
         carry_in.best_before = dist_past;
         carry_in.idx_before  = MY_IDX;
      end
      if (take_after) begin
         carry_in.have_after = 1'b1;
         carry_in.best_after = dist_future;
         carry_in.idx_after  = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign carry_next = carry_ff;

endmodule

`default_nettype wire

[src/vsync_frame_history_selector_core.sv]
// ----------------------------------------------------------------------------
// Frame history selector core
// Stores timestamped frames in a ring of cells and picks one per refresh.
// ----------------------------------------------------------------------------
// Usage: events arrive on the req channel (kind, time_now), one result beat
// leaves on the rsp channel for every event, and the user must write the
// refresh period through the csr channel only while the block is idle; the
// block does not enforce this. A frame event is stored when it lands less
// than two periods before the next present time, or later. A poll at or
// after the present time scans every history slot for the newest frame not
// later than the target, else the nearest later one. A present-done event
// sets the target to its own time plus one period.
// Frame events pass through EXEC, STORE and RESP; present-done, unused
// kinds and polls not yet due through EXEC and RESP; due polls through EXEC,
// SCAN and RESP, staying in SCAN while the search record walks the row of
// slot cells one cell per cycle. One event is handled at a time; the next
// request beat is taken while a finished result still sits in the output
// register. Reset clears the valid mark of every slot, the ring pointer and
// the present time, and loads the default period. When the receiver stalls,
// the result stays in the output register and the next result waits in
// the core until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module vsync_frame_history_selector_core #(
   parameter int unsigned HISTORY_DEPTH = vfhs_pkg::HISTORY_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   vfhs_req_if.sink   req_chan,
   vfhs_rsp_if.source rsp_chan,
   vfhs_csr_if.sink   csr_chan
);
   import vfhs_pkg::*;

   localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);

   // Control sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_STORE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [TICKS_W-1:0] ticks_ff;
   logic [TIME_W-1:0]  present_ff, present_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [TIME_W-1:0]  until_ff, until_in;
   result_type         res_ff, res_in;
   result_type         out_ff;
   logic               out_valid_ff;

   logic               req_fire;
   logic               out_load;
   logic               store_ok;
   logic               poll_due;
   logic               store_en;
   logic [TIME_W-1:0]  twice_ticks;

   scan_carry_type     scan_launch;
   scan_carry_type     chain [HISTORY_DEPTH+1];
   scan_carry_type     carry_last;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign out_load       = (state_ff == ST_RESP) && (!out_valid_ff || rsp_chan.ready);

   // Period register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else if (csr_chan.valid) begin
         ticks_ff <= csr_chan.data;
      end
   end

   // Capture the accepted event; it stays put until the result is built.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_chan.kind;
         time_ff <= req_chan.time_now;
      end
      until_ff <= until_in;
      res_ff   <= res_in;
   end

   // The store window compares a signed distance against twice the period,
   // which never goes negative since the period is only 32 bits wide.
   assign twice_ticks = {{(TIME_W-TICKS_W-1){1'b0}}, ticks_ff, 1'b0};
   assign store_ok    = $signed(until_ff) < $signed(twice_ticks);
   assign poll_due    = !($signed(time_ff) < $signed(present_ff));
   assign store_en    = (state_ff == ST_STORE) && store_ok;
   assign carry_last  = chain[HISTORY_DEPTH];
   assign chain[0]    = scan_launch;

   always_comb begin
      state_in    = state_ff;
      present_in  = present_ff;
      wp_in       = wp_ff;
      until_in    = until_ff;
      res_in      = res_ff;
      scan_launch = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            until_in = present_ff - time_ff;
            state_in = ST_RESP;
            case (kind_ff)
               KIND_FRAME: begin
                  state_in = ST_STORE;
               end
               KIND_POLL: begin
                  if (poll_due) begin
                     // Launch an empty search record into the first cell.
                     scan_launch.valid = 1'b1;
                     state_in          = ST_SCAN;
                  end
               end
               KIND_PRESENT_DONE: begin
                  present_in = time_ff + {{(TIME_W-TICKS_W){1'b0}}, ticks_ff};
               end
               default: begin
               end
            endcase
         end
         ST_STORE: begin
            if (store_ok) begin
               res_in.stored      = 1'b1;
               res_in.stored_slot = SLOT_FIELD_W'(wp_ff);
               wp_in = (wp_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (carry_last.valid) begin
               res_in.present_due = 1'b1;
               if (carry_last.have_before) begin
                  res_in.frame_found = 1'b1;
                  res_in.chosen_slot = carry_last.idx_before;
               end else if (carry_last.have_after) begin
                  res_in.frame_found = 1'b1;
                  res_in.chosen_slot = carry_last.idx_after;
                  res_in.from_future = 1'b1;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         present_ff <= '0;
         wp_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         wp_ff      <= wp_in;
      end
   end

   // Row of slot cells; the search record moves one cell per cycle.
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      vfhs_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (store_en && (wp_ff == PTR_W'(i))),
         .wr_time    (time_ff),
         .target     (present_ff),
         .carry_prev (chain[i]),
         .carry_next (chain[i+1])
      );
   end

   // Output register; it frees the core while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.stored      = out_ff.stored;
   assign rsp_chan.stored_slot = out_ff.stored_slot;
   assign rsp_chan.present_due = out_ff.present_due;
   assign rsp_chan.frame_found = out_ff.frame_found;
   assign rsp_chan.chosen_slot = out_ff.chosen_slot;
   assign rsp_chan.from_future = out_ff.from_future;

   // A search record only leaves the last cell while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      carry_last.valid |-> (state_ff == ST_SCAN))
      else $error("search record left the cell row outside a scan");

   // An accepted event always moves straight to execution.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted event did not start execution");

   // A selected frame only comes with a due poll.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_found) |-> out_ff.present_due)
      else $error("frame selected without a due poll");

   // A future frame is only reported together with a selection.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.from_future) |-> out_ff.frame_found)
      else $error("future flag without a selected frame");

   // A store and a selection never share one result beat.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.stored) |-> !out_ff.present_due)
      else $error("store and poll results mixed in one beat");

endmodule

`default_nettype wire
